### sv/bbtt_pkg.sv
// Shared types and constants for the brace-block text tokenizer.
package bbtt_pkg;

  // Token kinds carried in token_kind
  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_CHAR  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Character codes the lexer looks for
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  // Result queue sizing
  localparam int unsigned MAX_RESULTS = 2;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] char_out;
    logic       last_of_run;
  } out_word_t;

  // Results produced by one input byte: count and up to two words
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } lex_out_t;

endpackage

### sv/bbtt_lexer.sv
// Lexer mode register and per-byte token decode.
module bbtt_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbtt_pkg::in_word_t in_word_i,
  input  logic              accept_i,
  output bbtt_pkg::lex_out_t lex_o
);
  import bbtt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_QUOTED  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_WORD    = 3'd5
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic       emit;
    logic [1:0] kind;
    logic [7:0] ch;
  } idle_t;

  mode_e      mode_q, mode_d;
  idle_t      idle_r;
  lex_out_t   res;
  logic [7:0] b;
  logic [7:0] esc_ch;
  logic       last;

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_HYPHEN ||
           c == CH_DOT;
  endfunction

  // Handling of a byte seen outside any token
  function automatic idle_t idle_step(input logic [7:0] c);
    idle_t r;
    begin
      r = '{mode: MODE_IDLE, emit: 1'b0, kind: KIND_OPEN, ch: 8'h00};
      if (c == CH_SLASH) begin
        r.mode = MODE_SLASH;
      end else if (c == CH_LBRACE) begin
        r.emit = 1'b1;
        r.kind = KIND_OPEN;
      end else if (c == CH_RBRACE) begin
        r.emit = 1'b1;
        r.kind = KIND_CLOSE;
      end else if (c == CH_QUOTE) begin
        r.mode = MODE_QUOTED;
      end else if (is_word(c)) begin
        r.emit = 1'b1;
        r.kind = KIND_CHAR;
        r.ch   = c;
        r.mode = MODE_WORD;
      end
      return r;
    end
  endfunction

  // Append one result, drop it when two are already there
  function automatic lex_out_t push(input lex_out_t p, input logic [1:0] k,
                                    input logic [7:0] c);
    lex_out_t r;
    begin
      r = p;
      if (p.cnt == 2'd0) begin
        r.w0  = '{token_kind: k, char_out: c, last_of_run: 1'b0};
        r.cnt = 2'd1;
      end else if (p.cnt == 2'd1) begin
        r.w1  = '{token_kind: k, char_out: c, last_of_run: 1'b0};
        r.cnt = 2'd2;
      end
      return r;
    end
  endfunction

  assign b    = in_word_i.byte_in;
  assign last = in_word_i.end_of_text;

  // Map escape letters
  always_comb begin
    if (b == CH_N) begin
      esc_ch = CH_LF;
    end else if (b == CH_T) begin
      esc_ch = CH_TAB;
    end else begin
      esc_ch = b;
    end
  end

  // Decode one byte against the current mode
  always_comb begin
    idle_r = idle_step(b);
    mode_d = mode_q;
    res    = '0;
    unique case (mode_q)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          mode_d = idle_r.mode;
          if (idle_r.emit) res = push(res, idle_r.kind, idle_r.ch);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_LF) mode_d = MODE_IDLE;
      end
      MODE_QUOTED: begin
        if (b == CH_QUOTE) begin
          res    = push(res, KIND_END, 8'h00);
          mode_d = MODE_IDLE;
        end else if (b == CH_BSLASH) begin
          if (last) begin
            res = push(res, KIND_CHAR, CH_BSLASH);
          end else begin
            mode_d = MODE_ESCAPE;
          end
        end else begin
          res = push(res, KIND_CHAR, b);
        end
      end
      MODE_ESCAPE: begin
        res    = push(res, KIND_CHAR, esc_ch);
        mode_d = MODE_QUOTED;
      end
      MODE_WORD: begin
        if (is_word(b)) begin
          res = push(res, KIND_CHAR, b);
        end else begin
          res    = push(res, KIND_END, 8'h00);
          mode_d = idle_r.mode;
          if (idle_r.emit) res = push(res, idle_r.kind, idle_r.ch);
        end
      end
      default: begin
        mode_d = idle_r.mode;
        if (idle_r.emit) res = push(res, idle_r.kind, idle_r.ch);
      end
    endcase

    // Close an open string at end of text
    if (last) begin
      if (mode_d == MODE_QUOTED || mode_d == MODE_ESCAPE || mode_d == MODE_WORD) begin
        res = push(res, KIND_END, 8'h00);
      end
      mode_d = MODE_IDLE;
    end

    // Flag the final result of this byte
    if (res.cnt == 2'd1) begin
      res.w0.last_of_run = 1'b1;
    end else if (res.cnt == 2'd2) begin
      res.w1.last_of_run = 1'b1;
    end
  end

  assign lex_o = res;

  // Advance mode on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

### sv/bbtt_out_fifo.sv
// Result queue: takes up to two words per cycle, hands out one when the output is not stalled.
module bbtt_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bbtt_pkg::lex_out_t     lex_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bbtt_pkg::out_word_t    out_word_o,
  output logic [bbtt_pkg::CNT_W-1:0] fill_o
);
  import bbtt_pkg::*;

  out_word_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push      = push_i ? lex_i.cnt : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_word_o  = mem_q[rd_ptr_q];
  // Refuse input unless room for a full pair of results
  assign full_o      = (cnt_q > CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign fill_o      = cnt_q;

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_ptr_q] <= lex_i.w0;
    if (n_push == 2'd2) mem_q[wr_ptr_q + PTR_W'(1)] <= lex_i.w1;
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

endmodule

### sv/brace_block_text_tokenizer_top.sv
// Brace-block text tokenizer: byte stream in, token words out.
// Result words enter the result queue when their byte is accepted and leave it in order.
// Throughput: one byte per cycle while each byte yields at most one word and the output
// is not stalled; the two words of a byte leave one at a time through the single output
// port of the four-word result queue, which stalls input when it holds three or more.
// Reset: lexer mode returns to idle and the result queue empties.
module brace_block_text_tokenizer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bbtt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bbtt_pkg::out_word_t out_word_o
);
  import bbtt_pkg::*;

  logic             accept;
  logic             full;
  lex_out_t         lex;
  logic [CNT_W-1:0] fill;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Decode bytes into result words
  bbtt_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .accept_i  (accept),
    .lex_o     (lex)
  );

  // Queue result words toward the output
  bbtt_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .lex_i       (lex),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .fill_o      (fill)
  );

  // Queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A byte that yields results makes a word available next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && lex.cnt != 2'd0) |=> out_valid_o)
    else $error("results of accepted byte not offered");

  // Only the final result of a pair carries the run-end flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && lex.cnt == 2'd2) |-> (!lex.w0.last_of_run && lex.w1.last_of_run))
    else $error("bad last_of_run marking on result pair");

endmodule

### test/brace_block_text_tokenizer_top_test.sv
// Self-checking testbench for the brace-block text tokenizer top level.
module brace_block_text_tokenizer_top_test;
  import bbtt_pkg::*;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int BYTES_PER_PHASE  = 350;
  localparam int HOLD_CYCLES      = 80;
  localparam int DRAIN_CYCLES     = 4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_QUOTED,
    MODE_ESCAPE,
    MODE_WORD
  } lex_mode_e;

  // Tracks the lexer mode, predicts the tokens of each byte and checks output words
  class token_tracker;
    lex_mode_e mode;
    out_word_t pending_tokens[$];
    out_word_t byte_tokens[$];
    int        failures;
    int        words_checked;

    function new();
      mode = MODE_IDLE;
      failures = 0;
      words_checked = 0;
    endfunction

    function void note_failure(string msg);
      if (failures < 10) $display("tb: mismatch: %s", msg);
      failures++;
    endfunction

    function bit is_word_char(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             (b >= "0" && b <= "9") || b == CH_UNDER || b == CH_HYPHEN || b == CH_DOT;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] ch);
      out_word_t t;
      t.token_kind  = kind;
      t.char_out    = ch;
      t.last_of_run = 1'b0;
      byte_tokens.insert(byte_tokens.size(), t);
    endfunction

    function void idle_byte(logic [7:0] b);
      mode = MODE_IDLE;
      if (b == CH_SLASH) mode = MODE_SLASH;
      else if (b == CH_LBRACE) emit(KIND_OPEN, 8'h00);
      else if (b == CH_RBRACE) emit(KIND_CLOSE, 8'h00);
      else if (b == CH_QUOTE) mode = MODE_QUOTED;
      else if (is_word_char(b)) begin
        emit(KIND_CHAR, b);
        mode = MODE_WORD;
      end
    endfunction

    // Advance the lexer by one accepted byte and queue the tokens it yields
    function void take_byte(in_word_t w);
      logic [7:0] b;
      b = w.byte_in;
      byte_tokens.delete();
      case (mode)
        MODE_SLASH: begin
          if (b == CH_SLASH) mode = MODE_COMMENT;
          else idle_byte(b);
        end
        MODE_COMMENT: begin
          if (b == CH_LF) mode = MODE_IDLE;
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) begin
            emit(KIND_END, 8'h00);
            mode = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            // a backslash on the final byte stays a literal character
            if (w.end_of_text) emit(KIND_CHAR, CH_BSLASH);
            else mode = MODE_ESCAPE;
          end else begin
            emit(KIND_CHAR, b);
          end
        end
        MODE_ESCAPE: begin
          if (b == CH_N) emit(KIND_CHAR, CH_LF);
          else if (b == CH_T) emit(KIND_CHAR, CH_TAB);
          else emit(KIND_CHAR, b);
          mode = MODE_QUOTED;
        end
        MODE_WORD: begin
          if (is_word_char(b)) begin
            emit(KIND_CHAR, b);
          end else begin
            // the terminator closes the run, then counts as a fresh byte
            emit(KIND_END, 8'h00);
            idle_byte(b);
          end
        end
        default: idle_byte(b);
      endcase
      // close any open string at end of text; drop slash or comment
      if (w.end_of_text) begin
        if (mode == MODE_QUOTED || mode == MODE_ESCAPE || mode == MODE_WORD)
          emit(KIND_END, 8'h00);
        mode = MODE_IDLE;
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last_of_run = 1'b1;
      foreach (byte_tokens[i]) pending_tokens.insert(pending_tokens.size(), byte_tokens[i]);
    endfunction

    // Compare one output word with the oldest predicted token
    function void match_token(out_word_t got);
      out_word_t want;
      if (pending_tokens.size() == 0) begin
        note_failure($sformatf("unexpected word kind=%0d char=%02h last=%0b",
                               got.token_kind, got.char_out, got.last_of_run));
        return;
      end
      want = pending_tokens.pop_front();
      words_checked++;
      if (got.token_kind !== want.token_kind || got.char_out !== want.char_out ||
          got.last_of_run !== want.last_of_run)
        note_failure($sformatf(
          "word %0d expected kind=%0d char=%02h last=%0b, got kind=%0d char=%02h last=%0b",
          words_checked, want.token_kind, want.char_out, want.last_of_run,
          got.token_kind, got.char_out, got.last_of_run));
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  token_tracker tokens = new();
  logic [7:0]   doc_q[$];
  string        word_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.";
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int holds_done     = 0;
  int bytes_sent     = 0;
  int docs_sent      = 0;

  // Append one byte to the document being built
  function automatic void add_doc_byte(logic [7:0] b);
    doc_q.insert(doc_q.size(), b);
  endfunction

  brace_block_text_tokenizer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: long hold-offs first, else random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check output words before noting the byte taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tokens.match_token(out_word_o);
      if (in_valid_i && !in_stall_o) tokens.take_byte(in_word_i);
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{byte_in: b, end_of_text: eot};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Drop valid and wait until every predicted token has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tokens.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Build one document from random pieces; some are pure noise
  task automatic build_doc();
    int n;
    logic [7:0] b;
    doc_q.delete();
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) add_doc_byte(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(9))
        0: add_doc_byte(CH_LBRACE);
        1: add_doc_byte(CH_RBRACE);
        2, 3: begin
          add_doc_byte(CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) begin
            if ($urandom_range(3) == 0) begin
              add_doc_byte(CH_BSLASH);
              case ($urandom_range(2))
                0: add_doc_byte(CH_N);
                1: add_doc_byte(CH_T);
                default: add_doc_byte(8'($urandom_range(255)));
              endcase
            end else begin
              add_doc_byte(8'($urandom_range(255)));
            end
          end
          // leave some strings open
          if ($urandom_range(9) != 0) add_doc_byte(CH_QUOTE);
        end
        4, 5: begin
          n = $urandom_range(1, 6);
          repeat (n) add_doc_byte(word_chars[$urandom_range(word_chars.len() - 1)]);
        end
        6: begin
          case ($urandom_range(3))
            0: add_doc_byte(CH_SPACE);
            1: add_doc_byte(CH_TAB);
            2: add_doc_byte(CH_CR);
            default: add_doc_byte(CH_LF);
          endcase
        end
        7: begin
          add_doc_byte(CH_SLASH);
          add_doc_byte(CH_SLASH);
          n = $urandom_range(0, 5);
          repeat (n) begin
            do b = 8'($urandom_range(255)); while (b == CH_LF);
            add_doc_byte(b);
          end
          if ($urandom_range(3) != 0) add_doc_byte(CH_LF);
        end
        8: add_doc_byte(CH_SLASH);
        default: add_doc_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic send_doc();
    foreach (doc_q[i]) send_byte(doc_q[i], i == doc_q.size() - 1);
    docs_sent++;
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    int phase_start;
    directed_bytes = '{CH_LBRACE, "a", CH_RBRACE, CH_QUOTE, CH_BSLASH, CH_N, CH_BSLASH,
                       CH_T, CH_BSLASH, "q", 8'hFF, CH_QUOTE, CH_SLASH, "x", CH_SPACE,
                       CH_SLASH, CH_SLASH, 8'h00, CH_LF, 8'h80, CH_QUOTE, CH_BSLASH,
                       CH_QUOTE, "Z", CH_SLASH};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // directed words: the final four end documents on special bytes
      if (phase == 0) begin
        foreach (directed_bytes[i]) send_byte(directed_bytes[i], i >= 21);
        docs_sent++;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        build_doc();
        // hold the receiver off while the sender keeps pushing
        if (hold_left == 0 && (bytes_sent == phase_start || $urandom_range(19) == 0)) begin
          hold_left = HOLD_CYCLES;
          holds_done++;
        end
        send_doc();
        if ($urandom_range(9) == 0) wait_drained();
      end
      wait_drained();
    end

    if (tokens.pending() != 0)
      tokens.note_failure($sformatf("%0d tokens never arrived", tokens.pending()));
    $display("tb: %0d bytes in %0d documents, %0d token words checked, %0d mismatches",
             bytes_sent, docs_sent, tokens.words_checked, tokens.failures);
    $display("tb: four idle mixes, %0d long receiver hold-offs, drained pauses between docs",
             holds_done);
    if (tokens.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(20 * 400_000);
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
sv/bbtt_pkg.sv
sv/bbtt_lexer.sv
sv/bbtt_out_fifo.sv
sv/brace_block_text_tokenizer_top.sv
test/brace_block_text_tokenizer_top_test.sv
